// ----- sv/smk_pkg.sv -----
// smk_pkg: field widths, command and phase codes, modifier bits and the
// shared item, state, config and result types of the sticky modifier keys unit.
// Depends on nothing; every other file refers to it by scoped names.
package smk_pkg;

  localparam int unsigned ModW    = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;

  // Stream packing: tdata holds mod_code, phase, hold_ms, now_ms from bit 0 up.
  localparam int unsigned InUsedW   = CodeW + PhaseW + HoldW + TimeW;
  localparam int unsigned InTdataW  = ((InUsedW + 7) / 8) * 8;
  localparam int unsigned InTuserW  = CmdW;
  localparam int unsigned OutUsedW  = 3 * ModW;
  localparam int unsigned OutTdataW = ((OutUsedW + 7) / 8) * 8;

  // Command codes
  localparam logic [CmdW-1:0] CmdMod  = 2'd0;
  localparam logic [CmdW-1:0] CmdKey  = 2'd1;
  localparam logic [CmdW-1:0] CmdTick = 2'd2;

  // Modifier event phases
  localparam logic [PhaseW-1:0] PhPress   = 2'd0;
  localparam logic [PhaseW-1:0] PhHeld    = 2'd1;
  localparam logic [PhaseW-1:0] PhRelease = 2'd2;

  // Modifier code selections
  localparam logic [CodeW-1:0] CodeNone   = 3'd0;
  localparam logic [CodeW-1:0] CodeShift  = 3'd1;
  localparam logic [CodeW-1:0] CodeCtrl   = 3'd2;
  localparam logic [CodeW-1:0] CodeAlt    = 3'd3;
  localparam logic [CodeW-1:0] CodeGui    = 3'd4;
  localparam logic [CodeW-1:0] CodeAll    = 3'd5;
  localparam logic [CodeW-1:0] CodeMeh    = 3'd6;
  localparam logic [CodeW-1:0] CodeGuiCA  = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLockWindow = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAutoOff    = 1'b1;

  localparam logic [CfgW-1:0] LockWindowRst = 16'd300;
  localparam logic [CfgW-1:0] AutoOffRst    = 16'd1000;

  // Modifier bits
  localparam logic [ModW-1:0] BitShift = 4'b0001;
  localparam logic [ModW-1:0] BitCtrl  = 4'b0010;
  localparam logic [ModW-1:0] BitAlt   = 4'b0100;
  localparam logic [ModW-1:0] BitGui   = 4'b1000;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [CodeW-1:0]  mod_code;
    logic [PhaseW-1:0] phase;
    logic [HoldW-1:0]  hold_ms;
    logic [TimeW-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic [ModW-1:0] held;
    logic [ModW-1:0] sticky;
    logic [ModW-1:0] locked;
    logic [ModW-1:0] reported;
    logic            clear_pending;
    logic [TimeW-1:0] release_time;
  } state_t;

  typedef struct packed {
    logic [CfgW-1:0] lock_window_ms;
    logic [CfgW-1:0] auto_off_ms;
  } cfg_t;

  typedef struct packed {
    logic [ModW-1:0] release_mask;
    logic [ModW-1:0] press_mask;
    logic [ModW-1:0] active_mods;
  } result_t;

  function automatic logic [ModW-1:0] code_to_mask(input logic [CodeW-1:0] code);
    logic [ModW-1:0] m;
    unique case (code)
      CodeNone:  m = '0;
      CodeShift: m = BitShift;
      CodeCtrl:  m = BitCtrl;
      CodeAlt:   m = BitAlt;
      CodeGui:   m = BitGui;
      CodeAll:   m = BitShift | BitCtrl | BitAlt | BitGui;
      CodeMeh:   m = BitShift | BitCtrl | BitAlt;
      CodeGuiCA: m = BitGui | BitCtrl | BitAlt;
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/sticky_modifier_keys_unit.sv -----
// sticky_modifier_keys_unit: top level of the sticky (one-shot) modifier
// keys block. Depends on smk_pkg and instantiates smk_core.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: item fields, tuser: cmd
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: mods, press, release
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// Flow: one request per clock is accepted into the input register unless a
// stalled result already has a request waiting; when the result slot is free,
// the request's result is loaded into the result register and m_axis_tvalid rises.
// The state update in smk_core between those registers sets the rate of one
// item per cycle while the output is not stalled.
// Reset: rst_ni clears all masks, the pending clear, the release stamp and
// the stage valids, and loads the register reset values.
// Stalls: a held result with a request waiting in the input register drops
// s_axis_tready until the result is taken.
module sticky_modifier_keys_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // fields from bit 0: mod_code[2:0], phase[4:3], hold_ms[20:5], now_ms[52:21]
  input  logic [smk_pkg::InTdataW-1:0]   s_axis_tdata,
  // fields from bit 0: cmd[1:0]
  input  logic [smk_pkg::InTuserW-1:0]   s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // fields from bit 0: active_mods[3:0], press_mask[7:4], release_mask[11:8]
  output logic [smk_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [smk_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [smk_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int unsigned PhLo   = smk_pkg::CodeW;
  localparam int unsigned HoldLo = PhLo + smk_pkg::PhaseW;
  localparam int unsigned NowLo  = HoldLo + smk_pkg::HoldW;

  smk_pkg::item_t   in_item;
  smk_pkg::item_t   item_q;
  logic             item_vld_q;
  smk_pkg::state_t  state_q, state_d;
  smk_pkg::result_t res_d, res_q;
  logic             res_vld_q;
  smk_pkg::cfg_t    cfg_q;
  logic             res_free;
  logic             advance;
  logic             accept;

  // Unpack the incoming request.
  always_comb begin
    in_item.cmd      = s_axis_tuser[smk_pkg::CmdW-1:0];
    in_item.mod_code = s_axis_tdata[smk_pkg::CodeW-1:0];
    in_item.phase    = s_axis_tdata[HoldLo-1:PhLo];
    in_item.hold_ms  = s_axis_tdata[NowLo-1:HoldLo];
    in_item.now_ms   = s_axis_tdata[NowLo+smk_pkg::TimeW-1:NowLo];
  end

  // Advance the input register into the result slot whenever it is free.
  assign res_free      = !res_vld_q || m_axis_tready;
  assign advance       = item_vld_q && res_free;
  assign s_axis_tready = !item_vld_q || res_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item;
  end

  smk_core u_core (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Commit the state exactly once per item, as it moves to the result slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {{(smk_pkg::OutTdataW - smk_pkg::OutUsedW){1'b0}}, res_q};

  // Configuration writes always taken; user must keep block idle, not enforced.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lock_window_ms <= smk_pkg::LockWindowRst;
      cfg_q.auto_off_ms    <= smk_pkg::AutoOffRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        smk_pkg::CfgLockWindow: cfg_q.lock_window_ms <= cfg_data_i;
        smk_pkg::CfgAutoOff:    cfg_q.auto_off_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/smk_core.sv -----
// smk_core: next-state and report logic for one item of the sticky
// modifier keys unit. Purely combinational; uses smk_pkg types and codes.
module smk_core (
  input  smk_pkg::state_t  state_i,
  input  smk_pkg::item_t   item_i,
  input  smk_pkg::cfg_t    cfg_i,
  output smk_pkg::state_t  state_o,
  output smk_pkg::result_t result_o
);

  logic [smk_pkg::ModW-1:0]  mask;
  logic [smk_pkg::TimeW-1:0] elapsed;
  logic                      in_window;
  logic [smk_pkg::ModW-1:0]  cur;
  smk_pkg::state_t           st;

  assign mask      = smk_pkg::code_to_mask(item_i.mod_code);
  assign elapsed   = item_i.now_ms - state_i.release_time;
  assign in_window = elapsed <
                     {{(smk_pkg::TimeW - smk_pkg::CfgW){1'b0}}, cfg_i.lock_window_ms};

  always_comb begin
    st = state_i;
    unique case (item_i.cmd)
      smk_pkg::CmdMod: begin
        if (mask != '0) begin
          unique case (item_i.phase)
            smk_pkg::PhPress: begin
              if ((st.locked & mask) != '0) begin
                // press while locked: unlock and drop
                st.sticky = st.sticky & ~mask;
                st.locked = st.locked & ~mask;
              end else if ((st.sticky & mask) == mask) begin
                if (in_window) st.locked = st.locked | mask;
                else           st.sticky = st.sticky & ~mask;
              end else begin
                st.sticky = st.sticky | mask;
              end
              st.held = st.held | mask;
            end
            smk_pkg::PhHeld: begin
              if (item_i.hold_ms > cfg_i.auto_off_ms) st.sticky = st.sticky & ~mask;
            end
            smk_pkg::PhRelease: begin
              if ((st.sticky & mask) != '0) st.release_time = item_i.now_ms;
              st.held = st.held & ~mask;
            end
            default: ;
          endcase
        end
      end
      smk_pkg::CmdKey: begin
        if (st.sticky != '0) st.clear_pending = 1'b1;
      end
      smk_pkg::CmdTick: begin
        if (st.clear_pending) begin
          st.sticky        = '0;
          st.clear_pending = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign cur = st.held | st.sticky | st.locked;

  always_comb begin
    state_o          = st;
    state_o.reported = cur;
    result_o.active_mods  = cur;
    result_o.press_mask   = cur & ~state_i.reported;
    result_o.release_mask = state_i.reported & ~cur;
  end

endmodule

// ----- sv/smk_checker.sv -----
// smk_checker: port-level assertions for sticky_modifier_keys_unit,
// attached by the bind at the end. Depends on smk_pkg for widths.
module smk_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic [smk_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  logic [smk_pkg::ModW-1:0] act, prs, rel;
  assign act = m_axis_tdata[smk_pkg::ModW-1:0];
  assign prs = m_axis_tdata[2*smk_pkg::ModW-1:smk_pkg::ModW];
  assign rel = m_axis_tdata[3*smk_pkg::ModW-1:2*smk_pkg::ModW];

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Input backpressure only when the result slot is stalled.
  a_ready: assert property (@(posedge clk_i)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // Newly pressed bits are active, newly released bits are not.
  a_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((prs & ~act) == '0) && ((rel & act) == '0))
    else $error("press or release mask disagrees with active mods");

  // Nothing is reported while in reset.
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind sticky_modifier_keys_unit smk_checker u_smk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
